// File: rtl/rmf_pkg.sv
package rmf_pkg;

	localparam int WINDOW_LEN  = 10;
	localparam int SAMPLE_BITS = 12;
	localparam int IDX_W       = $clog2(WINDOW_LEN);
	localparam int ADR_W       = $clog2(WINDOW_LEN + 1);
	localparam int MID_IDX     = WINDOW_LEN / 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_SLOT_NEXT,
		RD_PREV,
		RD_NEXT2,
		RD_PREV2,
		RD_MID
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_FWD,
		WR_BWD,
		WR_CARRY
	} wr_op_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		wr_op_t  wr_op;
		logic    load_out;
	} rmf_cmd_t;

	typedef struct packed {
		logic fwd_hit;
		logic bwd_hit;
		logic last_fwd;
		logic last_bwd;
	} rmf_status_t;

endpackage

// File: rtl/rmf_datapath.sv
module rmf_datapath
	import rmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rmf_cmd_t    cmd,
	input  sample_t     sample,
	output sample_t     median,
	output rmf_status_t status
);

	sample_t                 mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]   vld_q;
	sample_t                 rd_q;
	sample_t                 carry_q;
	sample_t                 median_q;
	logic [IDX_W-1:0]        slot_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [ADR_W-1:0]        raddr;
	logic                    rd_en;
	logic                    wr_en;
	sample_t                 wdata;
	sample_t                 lo;
	sample_t                 hi;

	always_comb begin
		case (cmd.rd_sel)
			RD_SLOT_NEXT: raddr = ADR_W'(slot_q) + ADR_W'(1);
			RD_PREV:      raddr = ADR_W'(ptr_q) - ADR_W'(1);
			RD_NEXT2:     raddr = ADR_W'(ptr_q) + ADR_W'(2);
			RD_PREV2:     raddr = ADR_W'(ptr_q) - ADR_W'(2);
			RD_MID:       raddr = ADR_W'(MID_IDX);
			default:      raddr = '0;
		endcase
		rd_en = (cmd.rd_sel != RD_NONE) && (raddr < ADR_W'(WINDOW_LEN));
	end

	assign lo = (carry_q > rd_q) ? rd_q : carry_q;
	assign hi = (carry_q > rd_q) ? carry_q : rd_q;

	always_comb begin
		wr_en = 1'b1;
		case (cmd.wr_op)
			WR_FWD:   wdata = lo;
			WR_BWD:   wdata = hi;
			WR_CARRY: wdata = carry_q;
			default: begin
				wdata = carry_q;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= wdata;
		end
		if (rd_en) begin
			rd_q <= vld_q[raddr[IDX_W-1:0]] ? mem[raddr[IDX_W-1:0]] : '0;
		end
		if (cmd.load_out) begin
			median_q <= rd_q;
		end
		if (cmd.load) begin
			carry_q <= sample;
		end else if (cmd.wr_op == WR_FWD) begin
			carry_q <= hi;
		end else if (cmd.wr_op == WR_BWD) begin
			carry_q <= lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			slot_q <= '0;
			ptr_q  <= '0;
		end else begin
			if (wr_en) begin
				vld_q[ptr_q] <= 1'b1;
			end
			if (cmd.load) begin
				ptr_q  <= slot_q;
				slot_q <= (slot_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_q + IDX_W'(1);
			end else if (cmd.wr_op == WR_FWD) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end else if (cmd.wr_op == WR_BWD) begin
				ptr_q <= ptr_q - IDX_W'(1);
			end
		end
	end

	assign status.fwd_hit  = (ptr_q < IDX_W'(WINDOW_LEN - 1)) && (carry_q > rd_q);
	assign status.bwd_hit  = (ptr_q != '0) && (rd_q > carry_q);
	assign status.last_fwd = (ptr_q == IDX_W'(WINDOW_LEN - 2));
	assign status.last_bwd = (ptr_q == IDX_W'(1));
	assign median          = median_q;

endmodule

// File: rtl/rmf_ctrl.sv
module rmf_ctrl
	import rmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  rmf_status_t status,
	output rmf_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_R,
		ST_FWD,
		ST_CHK_L,
		ST_BWD,
		ST_WEND,
		ST_MED,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.rd_sel   = RD_NONE;
		cmd.wr_op    = WR_NONE;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					cmd.rd_sel = RD_SLOT_NEXT;
					state_d    = ST_CHK_R;
				end
			end
			ST_CHK_R, ST_FWD: begin
				if (state_q == ST_FWD || status.fwd_hit) begin
					cmd.wr_op = WR_FWD;
					if (status.last_fwd) begin
						state_d = ST_WEND;
					end else begin
						cmd.rd_sel = RD_NEXT2;
						state_d    = ST_FWD;
					end
				end else begin
					cmd.rd_sel = RD_PREV;
					state_d    = ST_CHK_L;
				end
			end
			ST_CHK_L, ST_BWD: begin
				if (state_q == ST_BWD || status.bwd_hit) begin
					cmd.wr_op = WR_BWD;
					if (status.last_bwd) begin
						state_d = ST_WEND;
					end else begin
						cmd.rd_sel = RD_PREV2;
						state_d    = ST_BWD;
					end
				end else begin
					cmd.wr_op = WR_CARRY;
					state_d   = ST_MED;
				end
			end
			ST_WEND: begin
				cmd.wr_op = WR_CARRY;
				state_d   = ST_MED;
			end
			ST_MED: begin
				cmd.rd_sel = RD_MID;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/running_median_filter.sv
// Running median filter over a ten-entry window of 12-bit samples. Each item
// overwrites the next slot in rotation, then one bubble pass (forward or
// backward, chosen by the new sample's neighbors) moves it toward its sorted
// place, and the median is the middle entry. The window sits in a small
// one-write/one-read RAM with registered read; the pass does one compare
// per cycle, and a forward pass runs on to the top slot, a backward pass
// down to the bottom slot.
// The window reads as zeros after reset with no clearing pass.
// A finished median waits in an output register, so the next item is taken
// while it is still pending; the median after that holds the filter until
// the pending one is taken.
module running_median_filter
	import rmf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t sample,
	output logic    out_valid,
	input  logic    out_ready,
	output sample_t median
);

	rmf_cmd_t    cmd;
	rmf_status_t status;

	rmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rmf_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.median (median),
		.status (status)
	);

endmodule

// File: sim/running_median_filter_test.sv
`timescale 1ns / 100ps

module running_median_filter_test;
	import rmf_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	sample_t sample;
	logic    out_valid;
	logic    out_ready;
	sample_t median;

	sample_t window_model [WINDOW_LEN];
	int      next_slot;
	sample_t median_q [$];
	sample_t last_sample;

	int errors;
	int items_sent;
	int medians_seen;
	bit src_idle_on;
	bit sink_idle_on;
	int sink_stall;

	running_median_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("timeout at %0t", $time);
		$display("running_median_filter_test failed");
		$finish;
	end

	// window update: overwrite slot, one bubble pass, take the middle entry
	function automatic sample_t update_window(sample_t s);
		int      p;
		int      i;
		sample_t t;
		p = next_slot;
		window_model[p] = s;
		if (p < WINDOW_LEN - 1 && window_model[p] > window_model[p + 1]) begin
			for (i = p; i < WINDOW_LEN - 1; i++) begin
				if (window_model[i] > window_model[i + 1]) begin
					t                   = window_model[i];
					window_model[i]     = window_model[i + 1];
					window_model[i + 1] = t;
				end
			end
		end else if (p > 0 && window_model[p - 1] > window_model[p]) begin
			for (i = p; i > 0; i--) begin
				if (window_model[i] < window_model[i - 1]) begin
					t                   = window_model[i];
					window_model[i]     = window_model[i - 1];
					window_model[i - 1] = t;
				end
			end
		end
		next_slot = (p + 1) % WINDOW_LEN;
		return window_model[MID_IDX];
	endfunction

	task automatic send_sample(sample_t s);
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		sample   = s;
		do @(posedge clk); while (!in_ready);
		median_q.push_back(update_window(s));
		last_sample = s;
		items_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (median_q.size() != 0) @(posedge clk);
	endtask

	// sink: ready with random stall bursts
	initial begin
		out_ready  = 1'b0;
		sink_stall = 0;
		forever begin
			@(negedge clk);
			if (sink_stall > 0) begin
				out_ready = 1'b0;
				sink_stall--;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				sink_stall = $urandom_range(1, 12) - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// result checker
	initial begin
		sample_t exp_median;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				medians_seen++;
				if (median_q.size() == 0) begin
					$display("%0t: unexpected median, actual %0d", $time, median);
					errors++;
				end else begin
					exp_median = median_q.pop_front();
					if (median !== exp_median) begin
						$display("%0t: median mismatch, expected %0d, actual %0d",
							$time, exp_median, median);
						errors++;
					end
				end
			end
		end
	end

	task automatic test_directed();
		sample_t seq [$];
		seq = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'hAAA, 12'h555, 12'd1,
			12'd2048, 12'd2048, 12'd2047, 12'd4095, 12'd0, 12'd3000, 12'd3000,
			12'd100, 12'd4094, 12'd1, 12'd0, 12'd4095, 12'd2500, 12'd2500,
			12'd10, 12'hFFF, 12'h800};
		foreach (seq[k]) send_sample(seq[k]);
	endtask

	task automatic test_random(int n);
		int      k;
		int      mode;
		int      run;
		sample_t base;
		sample_t s;
		k = 0;
		while (k < n) begin
			mode = $urandom_range(0, 4);
			run  = $urandom_range(3, 15);
			base = sample_t'($urandom_range(0, 4095));
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			repeat (run) begin
				case (mode)
					0: s = sample_t'($urandom_range(0, 4095));
					1: s = sample_t'(base + $urandom_range(0, 15) - 8);
					2: s = last_sample;
					3: s = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
					default: begin
						base = sample_t'(base + $urandom_range(0, 64));
						s    = base;
					end
				endcase
				send_sample(s);
				k++;
			end
		end
	endtask

	task automatic test_drain_pause(int n);
		repeat (n) begin
			send_sample(sample_t'($urandom_range(0, 4095)));
			if ($urandom_range(0, 7) == 0) begin
				drop_valid();
				wait_drained();
			end
		end
	endtask

	task automatic test_back_to_back(int n);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		repeat (n) send_sample(sample_t'($urandom_range(0, 4095)));
	endtask

	initial begin
		errors       = 0;
		items_sent   = 0;
		medians_seen = 0;
		next_slot    = 0;
		last_sample  = '0;
		foreach (window_model[k]) window_model[k] = '0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		sample   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(520);
		test_drain_pause(60);
		test_back_to_back(200);
		drop_valid();
		wait_drained();
		repeat (40) @(posedge clk);

		$display("Sent %0d samples (directed extremes, random runs, drain pauses,",
			items_sent);
		$display("back-to-back tail); %0d medians checked, %0d errors",
			medians_seen, errors);
		if (errors == 0 && median_q.size() == 0) begin
			$display("running_median_filter_test passed");
		end else begin
			$display("running_median_filter_test failed");
		end
		$finish;
	end

endmodule
